// ----- sv/deq_pkg.sv -----
// Shared types, constants and index helpers for the double-ended queue buffer.
// Depends on nothing; used by double_ended_queue_buffer.
package deq_pkg;

    // storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // input beat: one operation
    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] value;
    } in_beat_t;

    // output beat: one result per operation
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] popped_value;
        logic signed [DATA_WIDTH-1:0] front_value;
        logic signed [DATA_WIDTH-1:0] back_value;
        logic [CNT_W-1:0]             item_total;
        logic [1:0]                   status;
    } out_beat_t;

    // circular index add, both operands below DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- sv/double_ended_queue_buffer.sv -----
// Bounded double-ended queue of signed values held in one synchronous RAM.
// Depends on deq_pkg for beat types, operation and status codes.
//
// Usage: each beat on the s_ channel (s_valid/s_ready, payload s_data) is one
// operation: push front, push back, pop front, pop back or clear. Codes 5 to 7
// are idle operations that only report the current state. Every operation gives
// exactly one beat on the m_ channel (m_valid/m_ready, payload m_data) with the
// popped value, the front and back values after the operation, the entry count
// and a status (ok, pop on empty, push on full). Failed operations change nothing.
// Latency: m_valid rises at the clock edge after the one that accepts the
// operation, later only while the previous result still waits in the output register.
// Each operation passes through the read stage before the next one is accepted;
// there one registered entry RAM read per pop refreshes the cached front or back value.
// The next operation is accepted while a finished result waits in the output
// register; if the receiver stalls, the following operation waits in its read
// stage until the output register frees up, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; no RAM clearing pass is needed since the count bounds every read.
module double_ended_queue_buffer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  deq_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output deq_pkg::out_beat_t m_data
);

    localparam int DEPTH  = deq_pkg::DEPTH;
    localparam int DW     = deq_pkg::DATA_WIDTH;
    localparam int ADDR_W = deq_pkg::ADDR_W;
    localparam int CNT_W  = deq_pkg::CNT_W;

    typedef enum logic {S_IDLE, S_READ} state_t;

    // which cached end the RAM read refreshes
    typedef enum logic [1:0] {LD_NONE, LD_FRONT, LD_BACK} load_t;

    state_t                 state_reg,  state_next;
    logic [ADDR_W-1:0]      head_reg,   head_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic signed [DW-1:0]   front_reg,  front_next;
    logic signed [DW-1:0]   back_reg,   back_next;
    load_t                  load_reg,   load_next;
    logic signed [DW-1:0]   popped_reg, popped_next;
    logic [1:0]             status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    deq_pkg::out_beat_t     out_reg,    out_next;

    logic signed [DW-1:0]   mem [DEPTH];
    logic signed [DW-1:0]   rdata_reg;
    logic                   wr_en, rd_en;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;

    logic                   accept;
    logic                   is_empty, is_full;
    logic [ADDR_W-1:0]      head_inc, head_dec, tail_slot, tail_prev;
    logic signed [DW-1:0]   front_res, back_res;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // index arithmetic around the circular store
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign head_inc  = deq_pkg::wrap_add(head_reg, ADDR_W'(1));
    assign head_dec  = deq_pkg::wrap_add(head_reg, ADDR_W'(DEPTH - 1));
    assign tail_slot = deq_pkg::wrap_add(head_reg, count_reg[ADDR_W-1:0]);
    assign tail_prev = deq_pkg::wrap_add(head_reg,
                                         ADDR_W'(count_reg - CNT_W'(2)));

    // refreshed ends once the RAM read data is back
    assign front_res = (load_reg == LD_FRONT) ? rdata_reg : front_reg;
    assign back_res  = (load_reg == LD_BACK)  ? rdata_reg : back_reg;

    // operation decode and result assembly
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        load_next    = load_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = head_reg;
        rd_addr      = head_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next  = S_READ;
                    load_next   = LD_NONE;
                    popped_next = '0;
                    status_next = deq_pkg::ST_OK;
                    case (s_data.op)
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = deq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CNT_W'(1);
                                front_next = s_data.value;
                                if (is_empty) begin
                                    back_next = s_data.value;
                                end
                            end
                        end
                        deq_pkg::OP_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = deq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_slot;
                                count_next = count_reg + CNT_W'(1);
                                back_next  = s_data.value;
                                if (is_empty) begin
                                    front_next = s_data.value;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                popped_next = front_reg;
                                head_next   = head_inc;
                                count_next  = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1)) begin
                                    front_next = '0;
                                    back_next  = '0;
                                end else begin
                                    rd_en     = 1'b1;
                                    rd_addr   = head_inc;
                                    load_next = LD_FRONT;
                                end
                            end
                        end
                        deq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                popped_next = back_reg;
                                count_next  = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1)) begin
                                    front_next = '0;
                                    back_next  = '0;
                                end else begin
                                    rd_en     = 1'b1;
                                    rd_addr   = tail_prev;
                                    load_next = LD_BACK;
                                end
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            head_next  = '0;
                            count_next = '0;
                            front_next = '0;
                            back_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    front_next            = front_res;
                    back_next             = back_res;
                    load_next             = LD_NONE;
                    out_next.popped_value = popped_reg;
                    out_next.front_value  = front_res;
                    out_next.back_value   = back_res;
                    out_next.item_total   = count_reg;
                    out_next.status       = status_reg;
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            front_reg   <= '0;
            back_reg    <= '0;
            load_reg    <= LD_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            load_reg    <= load_next;
            m_valid_reg <= m_valid_next;
        end
        popped_reg <= popped_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    // entry RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_data.value;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_accept_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_READ))
        else $error("accepted beat did not move to read stage");

    a_empty_zero_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.item_total == '0) |->
        (out_reg.front_value == '0 && out_reg.back_value == '0))
        else $error("empty queue reports nonzero front or back");

    a_fail_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != deq_pkg::ST_OK) |->
        (out_reg.popped_value == '0))
        else $error("failed operation reports a popped value");
`endif

endmodule
